// ----- sv/rtxhs_pkg.sv -----
// ----------------------------------------------------------------------------
// rtxhs_pkg: transmit handoff sequencer types and codes
// Command, operation, phase, action and result codes shared by the front
// end, the operation queue and the back end.
// ----------------------------------------------------------------------------
package rtxhs_pkg;

	localparam int unsigned CMD_W      = 3;
	localparam int unsigned LEN_W      = 8;
	localparam int unsigned PLEN_W     = 6;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned QDEPTH     = 2;
	localparam int unsigned QPTR_W     = $clog2(QDEPTH);
	localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

	localparam logic [CFG_DATA_W-1:0] SETTLE_RST  = 16'd250;
	localparam logic [CFG_DATA_W-1:0] TIMEOUT_RST = 16'd20000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETTLE  = 2'd0,
		REG_TIMEOUT = 2'd1,
		REG_READY   = 2'd2
	} reg_idx_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 3'd0,
		CMD_START  = 3'd1,
		CMD_STATUS = 3'd2,
		CMD_LOAD   = 3'd3,
		CMD_TAKE   = 3'd4
	} cmd_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_TICK,
		OP_START_OK,
		OP_START_BAD,
		OP_SENT,
		OP_RETRY,
		OP_LOAD_OK,
		OP_LOAD_FAIL,
		OP_TAKE
	} op_t;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_TX_SETTLE = 3'd1,
		PH_LOAD      = 3'd2,
		PH_TX_WAIT   = 3'd3,
		PH_RX_SETTLE = 3'd4
	} phase_t;

	typedef enum logic [3:0] {
		ACT_NONE        = 4'd0,
		ACT_REJ_INVALID = 4'd1,
		ACT_REJ_BUSY    = 4'd2,
		ACT_ENTER_TX    = 4'd3,
		ACT_LOAD_PULSE  = 4'd4,
		ACT_SUCCESS_RX  = 4'd5,
		ACT_RETRY_RX    = 4'd6,
		ACT_TIMEOUT_RX  = 4'd7,
		ACT_LDFAIL_RX   = 4'd8,
		ACT_RX_ENABLE   = 4'd9
	} action_t;

	typedef enum logic [1:0] {
		RES_NONE = 2'd0,
		RES_OK   = 2'd1,
		RES_FAIL = 2'd2
	} res_t;

	typedef struct packed {
		op_t               op;
		logic [PLEN_W-1:0] len;
	} q_item_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] settle;
		logic [CFG_DATA_W-1:0] timeout;
	} cfg_t;

endpackage

// ----- sv/radio_tx_handoff_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// radio_tx_handoff_sequencer_core: transmit handoff sequencer
// Sequences a half-duplex radio from receive standby through transmit and
// back, driven by tick, start, status, load-outcome and take words.
//
// Input channel: in_valid/in_stall with cmd, length, sent_flag,
//   retry_limit_flag and load_ok. Every accepted word yields exactly one
//   result word on the output channel out_valid/out_stall with action,
//   busy_res, phase, taken_result and payload_length.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index 0 settle
//   ticks, 1 timeout ticks, 2 radio ready. cfg_ready is always high; write
//   only while no word is in flight.
// Path: an accepted word is written into the queue, then moved into the
//   result register when the output is free.
// Throughput: one word per cycle while the output is not stalled; the
//   classifier feeds a two-entry queue and the back end retires one queued
//   operation per cycle into the result register.
// Stall: a stalled result holds; the queue absorbs two more words, then
//   in_stall rises until the result is taken.
// Reset: phase idle, timers and results cleared, configuration at its
//   reset values, queue and result register empty.
// ----------------------------------------------------------------------------
module radio_tx_handoff_sequencer_core #(
	parameter int unsigned MAX_PAYLOAD = 32,
	parameter int unsigned TIMER_BITS  = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rtxhs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rtxhs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [rtxhs_pkg::CMD_W-1:0]      cmd,
	input  logic [rtxhs_pkg::LEN_W-1:0]      length,
	input  logic                             sent_flag,
	input  logic                             retry_limit_flag,
	input  logic                             load_ok,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [3:0]                       action,
	output logic                             busy_res,
	output logic [2:0]                       phase,
	output logic [1:0]                       taken_result,
	output logic [rtxhs_pkg::PLEN_W-1:0]     payload_length
);
	import rtxhs_pkg::*;

	q_item_t fr_item;
	q_item_t head_item;
	cfg_t    cfg;
	logic    q_full;
	logic    head_valid;
	logic    pop;

	rtxhs_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.cmd              (cmd),
		.length           (length),
		.sent_flag        (sent_flag),
		.retry_limit_flag (retry_limit_flag),
		.load_ok          (load_ok),
		.item             (fr_item),
		.cfg              (cfg)
	);

	assign in_stall = q_full;

	rtxhs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_valid && !in_stall),
		.push_item  (fr_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	rtxhs_back #(
		.TIMER_BITS(TIMER_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_item      (head_item),
		.pop            (pop),
		.cfg            (cfg),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.action         (action),
		.busy_res       (busy_res),
		.phase          (phase),
		.taken_result   (taken_result),
		.payload_length (payload_length)
	);

	a_plen_only_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action != ACT_LOAD_PULSE) |-> (payload_length == '0))
		else $error("payload length outside load action");

	a_load_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == ACT_LOAD_PULSE) |-> (phase == PH_LOAD))
		else $error("load action without load phase");

	a_take_no_action: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (taken_result != RES_NONE) |-> (action == ACT_NONE))
		else $error("taken result alongside an action");

	a_rx_enable_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == ACT_RX_ENABLE) |-> !busy_res)
		else $error("rx enable without returning to idle");

	a_stall_when_backed: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> head_valid && out_valid)
		else $error("input stalled with no result waiting");

endmodule

// ----- sv/rtxhs_front.sv -----
// ----------------------------------------------------------------------------
// rtxhs_front: configuration registers and command classification
// Holds the configuration registers, checks start requests and turns each
// accepted word into a queue operation.
// ----------------------------------------------------------------------------
module rtxhs_front #(
	parameter int unsigned MAX_PAYLOAD = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rtxhs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rtxhs_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [rtxhs_pkg::CMD_W-1:0]         cmd,
	input  logic [rtxhs_pkg::LEN_W-1:0]         length,
	input  logic                                sent_flag,
	input  logic                                retry_limit_flag,
	input  logic                                load_ok,
	output rtxhs_pkg::q_item_t                  item,
	output rtxhs_pkg::cfg_t                     cfg
);
	import rtxhs_pkg::*;

	logic [CFG_DATA_W-1:0] settle_q;
	logic [CFG_DATA_W-1:0] timeout_q;
	logic                  ready_q;
	logic                  len_bad;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q  <= SETTLE_RST;
			timeout_q <= TIMEOUT_RST;
			ready_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SETTLE:  settle_q  <= cfg_data;
				REG_TIMEOUT: timeout_q <= cfg_data;
				REG_READY:   ready_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg.settle  = settle_q;
	assign cfg.timeout = timeout_q;

	assign len_bad = (length == '0) || (length > LEN_W'(MAX_PAYLOAD));

	always_comb begin
		item.len = length[PLEN_W-1:0];
		unique case (cmd)
			CMD_TICK:   item.op = OP_TICK;
			CMD_START:  item.op = (len_bad || !ready_q) ? OP_START_BAD : OP_START_OK;
			CMD_STATUS: begin
				priority if (sent_flag)        item.op = OP_SENT;
				else if (retry_limit_flag)     item.op = OP_RETRY;
				else                           item.op = OP_NOP;
			end
			CMD_LOAD:   item.op = load_ok ? OP_LOAD_OK : OP_LOAD_FAIL;
			CMD_TAKE:   item.op = OP_TAKE;
			default:    item.op = OP_NOP;
		endcase
	end

endmodule

// ----- sv/rtxhs_queue.sv -----
// ----------------------------------------------------------------------------
// rtxhs_queue: operation queue
// Short first-in first-out queue of classified operations between the
// front end and the back end.
// ----------------------------------------------------------------------------
module rtxhs_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rtxhs_pkg::q_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output rtxhs_pkg::q_item_t head_item
);
	import rtxhs_pkg::*;

	q_item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- sv/rtxhs_back.sv -----
// ----------------------------------------------------------------------------
// rtxhs_back: sequencer state and result register
// Carries out queued operations against the phase, timer and result state
// and holds each result word until the receiver takes it.
// ----------------------------------------------------------------------------
module rtxhs_back #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             head_valid,
	input  rtxhs_pkg::q_item_t               head_item,
	output logic                             pop,
	input  rtxhs_pkg::cfg_t                  cfg,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [3:0]                       action,
	output logic                             busy_res,
	output logic [2:0]                       phase,
	output logic [1:0]                       taken_result,
	output logic [rtxhs_pkg::PLEN_W-1:0]     payload_length
);
	import rtxhs_pkg::*;

	localparam int unsigned CW = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;

	phase_t                phase_q,    phase_n;
	logic [TIMER_BITS-1:0] elapsed_q,  elapsed_n;
	res_t                  pending_q,  pending_n;
	res_t                  finished_q, finished_n;
	logic [PLEN_W-1:0]     len_q,      len_n;

	action_t               act_n;
	res_t                  taken_n;
	logic [PLEN_W-1:0]     plen_n;

	logic                  out_valid_q;
	action_t               action_q;
	phase_t                phase_out_q;
	res_t                  taken_q;
	logic [PLEN_W-1:0]     plen_q;

	logic [TIMER_BITS-1:0] el_inc;
	logic                  settle_done;
	logic                  timeout_done;

	assign pop = head_valid && (!out_valid_q || !out_stall);

	assign el_inc       = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
	assign settle_done  = CW'(el_inc) >= CW'(cfg.settle);
	assign timeout_done = CW'(el_inc) >= CW'(cfg.timeout);

	always_comb begin
		phase_n    = phase_q;
		elapsed_n  = elapsed_q;
		pending_n  = pending_q;
		finished_n = finished_q;
		len_n      = len_q;
		act_n      = ACT_NONE;
		taken_n    = RES_NONE;
		plen_n     = '0;
		unique case (head_item.op)
			OP_TICK: begin
				unique case (phase_q)
					PH_TX_SETTLE: begin
						elapsed_n = el_inc;
						if (settle_done) begin
							act_n   = ACT_LOAD_PULSE;
							plen_n  = len_q;
							phase_n = PH_LOAD;
						end
					end
					PH_TX_WAIT: begin
						elapsed_n = el_inc;
						if (timeout_done) begin
							act_n     = ACT_TIMEOUT_RX;
							pending_n = RES_FAIL;
							phase_n   = PH_RX_SETTLE;
							elapsed_n = '0;
						end
					end
					PH_RX_SETTLE: begin
						elapsed_n = el_inc;
						if (settle_done) begin
							act_n      = ACT_RX_ENABLE;
							finished_n = pending_q;
							pending_n  = RES_NONE;
							phase_n    = PH_IDLE;
						end
					end
					default: ;
				endcase
			end
			OP_START_BAD: act_n = ACT_REJ_INVALID;
			OP_START_OK: begin
				if (phase_q != PH_IDLE) begin
					act_n = ACT_REJ_BUSY;
				end else begin
					len_n      = head_item.len;
					pending_n  = RES_NONE;
					finished_n = RES_NONE;
					phase_n    = PH_TX_SETTLE;
					elapsed_n  = '0;
					act_n      = ACT_ENTER_TX;
				end
			end
			OP_SENT, OP_RETRY: begin
				if (phase_q == PH_TX_WAIT) begin
					act_n     = (head_item.op == OP_SENT) ? ACT_SUCCESS_RX : ACT_RETRY_RX;
					pending_n = (head_item.op == OP_SENT) ? RES_OK : RES_FAIL;
					phase_n   = PH_RX_SETTLE;
					elapsed_n = '0;
				end
			end
			OP_LOAD_OK: begin
				if (phase_q == PH_LOAD) begin
					phase_n   = PH_TX_WAIT;
					elapsed_n = '0;
				end
			end
			OP_LOAD_FAIL: begin
				if (phase_q == PH_LOAD) begin
					act_n     = ACT_LDFAIL_RX;
					pending_n = RES_FAIL;
					phase_n   = PH_RX_SETTLE;
					elapsed_n = '0;
				end
			end
			OP_TAKE: begin
				taken_n    = finished_q;
				finished_n = RES_NONE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			elapsed_q   <= '0;
			pending_q   <= RES_NONE;
			finished_q  <= RES_NONE;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q    <= phase_n;
				elapsed_q  <= elapsed_n;
				pending_q  <= pending_n;
				finished_q <= finished_n;
				len_q      <= len_n;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			action_q    <= act_n;
			phase_out_q <= phase_n;
			taken_q     <= taken_n;
			plen_q      <= plen_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign action         = action_q;
	assign phase          = phase_out_q;
	assign busy_res       = (phase_out_q != PH_IDLE);
	assign taken_result   = taken_q;
	assign payload_length = plen_q;

endmodule
